>>> rtl/core/chacha_pkg.sv
// Types, constants and round functions shared by the ChaCha20 permutation pipeline
`timescale 1ns / 1ps

package chacha_pkg;

    localparam int WordW      = 32;
    localparam int WordCount  = 16;
    localparam int Rounds     = 20;
    // each round is split into two register stages: rotations 16/12, then 8/7
    localparam int StageCount = 2 * Rounds;

    localparam int RotA = 16;
    localparam int RotB = 12;
    localparam int RotC = 8;
    localparam int RotD = 7;

    typedef logic [WordCount-1:0][WordW-1:0] t_state;

    typedef struct packed {
        logic [63:0] in_words_14_15;
        logic [63:0] in_words_12_13;
        logic [63:0] in_words_10_11;
        logic [63:0] in_words_8_9;
        logic [63:0] in_words_6_7;
        logic [63:0] in_words_4_5;
        logic [63:0] in_words_2_3;
        logic [63:0] in_words_0_1;
    } t_req;

    typedef struct packed {
        logic [63:0] out_words_14_15;
        logic [63:0] out_words_12_13;
        logic [63:0] out_words_10_11;
        logic [63:0] out_words_8_9;
        logic [63:0] out_words_6_7;
        logic [63:0] out_words_4_5;
        logic [63:0] out_words_2_3;
        logic [63:0] out_words_0_1;
    } t_res;

    function automatic logic [WordW-1:0] rotl(logic [WordW-1:0] x, int n);
        return (x << n) | (x >> (WordW - n));
    endfunction

    // Request fields to state words, lower word in the low half
    function automatic t_state unpack_req(t_req r);
        t_state s;
        s[0]  = r.in_words_0_1[31:0];    s[1]  = r.in_words_0_1[63:32];
        s[2]  = r.in_words_2_3[31:0];    s[3]  = r.in_words_2_3[63:32];
        s[4]  = r.in_words_4_5[31:0];    s[5]  = r.in_words_4_5[63:32];
        s[6]  = r.in_words_6_7[31:0];    s[7]  = r.in_words_6_7[63:32];
        s[8]  = r.in_words_8_9[31:0];    s[9]  = r.in_words_8_9[63:32];
        s[10] = r.in_words_10_11[31:0];  s[11] = r.in_words_10_11[63:32];
        s[12] = r.in_words_12_13[31:0];  s[13] = r.in_words_12_13[63:32];
        s[14] = r.in_words_14_15[31:0];  s[15] = r.in_words_14_15[63:32];
        return s;
    endfunction

    function automatic t_res pack_res(t_state s);
        t_res r;
        r.out_words_0_1   = {s[1],  s[0]};
        r.out_words_2_3   = {s[3],  s[2]};
        r.out_words_4_5   = {s[5],  s[4]};
        r.out_words_6_7   = {s[7],  s[6]};
        r.out_words_8_9   = {s[9],  s[8]};
        r.out_words_10_11 = {s[11], s[10]};
        r.out_words_12_13 = {s[13], s[12]};
        r.out_words_14_15 = {s[15], s[14]};
        return r;
    endfunction

    // Half of a column (diag=0) or diagonal (diag=1) round on all four lanes.
    // second=0 does the 16/12 half of each quarter round, second=1 the 8/7 half.
    function automatic t_state half_round(t_state s, logic diag, logic second);
        t_state           n;
        logic [1:0]       j;
        logic [3:0]       ia, ib, ic, id;
        logic [WordW-1:0] a, b, c, d;
        n = s;
        for (int i = 0; i < 4; i++) begin
            j  = 2'(i);
            ia = {2'b00, j};
            ib = {2'b01, 2'(j + {1'b0, diag})};
            ic = {2'b10, 2'(j + {diag, 1'b0})};
            id = {2'b11, 2'(j + {diag, diag})};
            a  = s[ia];
            b  = s[ib];
            c  = s[ic];
            d  = s[id];
            a  = a + b;
            d  = rotl(d ^ a, second ? RotC : RotA);
            c  = c + d;
            b  = rotl(b ^ c, second ? RotD : RotB);
            n[ia] = a;
            n[ib] = b;
            n[ic] = c;
            n[id] = d;
        end
        return n;
    endfunction

endpackage

>>> rtl/core/chacha20_permutation.sv
// ChaCha20 bare core permutation, fully pipelined with two stages per round
`timescale 1ns / 1ps

// One 512-bit block enters on any cycle that i_start is high; o_busy is
// always low since the pipeline never stalls. Each round of 20 is split into
// two register stages (the 16/12 and the 8/7 halves of the quarter rounds),
// so a result appears on o_res with o_done high exactly 40 cycles after its
// request, in request order, for one cycle only: the receiver must take it
// then. Throughput is one block per cycle. No feed-forward add is applied.
module chacha20_permutation
    import chacha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    input  t_req i_req,
    output logic o_done,
    output t_res o_res
);

    logic   r_valid [StageCount];
    t_state r_st    [StageCount];

    // stage 0 takes the request, stage k works on stage k-1
    for (genvar k = 0; k < StageCount; k++) begin : g_stage
        localparam logic Diag   = 1'((k / 2) % 2);
        localparam logic Second = 1'(k % 2);

        logic   n_valid;
        t_state n_st;

        if (k == 0) begin : g_first
            assign n_valid = i_start;
            assign n_st    = half_round(unpack_req(i_req), Diag, Second);
        end else begin : g_rest
            assign n_valid = r_valid[k-1];
            assign n_st    = half_round(r_st[k-1], Diag, Second);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else begin
                r_valid[k] <= n_valid;
            end
        end

        // payload needs no reset
        always_ff @(posedge i_clk) begin
            r_st[k] <= n_st;
        end
    end

    assign o_busy = 1'b0;
    assign o_done = r_valid[StageCount-1];
    assign o_res  = pack_res(r_st[StageCount-1]);

endmodule
